>>> rtl/mssr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mssr_pkg;

	// Fixed field widths
	localparam int PWM_W  = 16;
	localparam int POT_W  = 10;
	localparam int TIME_W = 14;
	localparam int REQ_W  = 3;

	// Ramp time = (RT_BASE + pot scaled to 0..RT_SPAN) * RT_UNIT_MS
	localparam int RT_BASE    = 50;
	localparam int RT_SPAN    = 50;
	localparam int RT_UNIT_MS = 100;

	localparam logic [PWM_W-1:0] PWM_TOP_RST = 16'd7999;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK      = 3'd0,
		REQ_START     = 3'd1,
		REQ_MODE      = 3'd2,
		REQ_STOP      = 3'd3,
		REQ_TIME_POT  = 3'd4,
		REQ_SPEED_POT = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		OC_NONE  = 2'd0,
		OC_DONE  = 2'd1,
		OC_ABORT = 2'd2
	} outcome_t;

	// What the scaling pipeline does with the compare value
	typedef enum logic [1:0] {
		CMP_HOLD  = 2'd0,
		CMP_CLEAR = 2'd1,
		CMP_LOAD  = 2'd2
	} cmp_op_t;

	typedef struct packed {
		logic               mode_normal;
		logic               ramping;
		logic               running;
		logic               select_time;
		outcome_t           outcome;
		logic [TIME_W-1:0]  ramp_time;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/mssr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mssr_ctrl #(
	parameter int RAMP_STEPS = 100,
	parameter int ADC_BITS   = 10,
	localparam int ACC_W     = $clog2(RAMP_STEPS * ((1 << ADC_BITS) - 1) + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mssr_pkg::REQ_W-1:0]           req_type,
	input  logic [mssr_pkg::POT_W-1:0]           pot_value,
	output logic                                 dn_valid,
	input  logic                                 dn_ready,
	output mssr_pkg::status_t                    dn_status,
	output mssr_pkg::cmp_op_t                    dn_op,
	output logic [ACC_W-1:0]                     dn_acc
);

	localparam int TIME_W  = mssr_pkg::TIME_W;
	localparam int ADC_MAX = (1 << ADC_BITS) - 1;
	localparam int PW      = (mssr_pkg::POT_W > ADC_BITS) ? mssr_pkg::POT_W : ADC_BITS;
	localparam int Q_W     = $clog2(mssr_pkg::RT_SPAN + 1);
	localparam int NQ_W    = ADC_BITS + Q_W;
	// delta = T / RAMP_STEPS by reciprocal multiply
	localparam int DS      = TIME_W + $clog2(RAMP_STEPS);
	localparam longint unsigned DM =
		((64'd1 << DS) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS);
	localparam int DM_W    = $clog2(DM + 1);
	localparam int DP_W    = TIME_W + DM_W;

	// input stage
	logic                              v1_q;
	mssr_pkg::req_t                    req_s1;
	logic [mssr_pkg::POT_W-1:0]        pot_s1;
	logic                              rdy2;
	logic                              fire1;

	// state
	logic                 normal_q, select_q, ramp_q, run_q;
	logic [ADC_BITS-1:0]  pot_time_q, pot_speed_q, speed_q;
	logic [TIME_W-1:0]    ramp_time_q, elapsed_q, last_step_q, delta_q;
	logic [ACC_W-1:0]     acc_q;

	logic                 normal_d, select_d, ramp_d, run_d;
	logic [ADC_BITS-1:0]  pot_time_d, pot_speed_d, speed_d;
	logic [TIME_W-1:0]    rt_d, elapsed_d, last_d;
	logic [ACC_W-1:0]     acc_d;
	mssr_pkg::cmp_op_t    op_d;
	mssr_pkg::outcome_t   oc_d;

	// output stage
	logic                 v2_q;
	mssr_pkg::status_t    status_s2;
	mssr_pkg::cmp_op_t    op_s2;
	logic [ACC_W-1:0]     acc_s2;

	// datapath
	logic [PW-1:0]        pot_ext;
	logic [ADC_BITS-1:0]  pot_sat;
	logic [NQ_W-1:0]      span_prod;
	logic [Q_W-1:0]       q0, qfix;
	logic [ADC_BITS:0]    rsum;
	logic [TIME_W-1:0]    rt_new;
	logic [DP_W-1:0]      delta_prod;
	logic [TIME_W:0]      elapsed_inc;
	logic [TIME_W-1:0]    elapsed_next, gap;
	logic                 ramp_done, step_due;
	logic [ACC_W-1:0]     cap, acc_step;
	logic [ACC_W:0]       acc_sum;

	assign rdy2     = !v2_q || dn_ready;
	assign fire1    = v1_q && rdy2;
	assign in_ready = !v1_q || rdy2;

	// pot sample saturation
	assign pot_ext = PW'(pot_s1);
	assign pot_sat = (pot_ext > PW'(ADC_MAX)) ? ADC_BITS'(ADC_MAX) : ADC_BITS'(pot_ext);

	// floor(pot_time * span / ADC_MAX): split at 2^ADC_BITS, one fix-up
	assign span_prod = NQ_W'(pot_time_q) * NQ_W'(mssr_pkg::RT_SPAN);
	assign q0        = Q_W'(span_prod >> ADC_BITS);
	assign rsum      = {1'b0, span_prod[ADC_BITS-1:0]} + (ADC_BITS + 1)'(q0);
	assign qfix      = q0 + Q_W'(rsum >= (ADC_BITS + 1)'(ADC_MAX));
	assign rt_new    = TIME_W'((TIME_W'(mssr_pkg::RT_BASE) + TIME_W'(qfix))
		* TIME_W'(mssr_pkg::RT_UNIT_MS));

	assign delta_prod = DP_W'(ramp_time_q) * DP_W'(DM);

	// ramp step
	assign elapsed_inc  = {1'b0, elapsed_q} + (TIME_W + 1)'(1);
	assign elapsed_next = elapsed_inc[TIME_W-1:0];
	assign ramp_done    = elapsed_inc > {1'b0, ramp_time_q};
	assign gap          = elapsed_next - last_step_q;
	assign step_due     = (elapsed_next < last_step_q) || (gap >= delta_q);
	assign cap          = ACC_W'(RAMP_STEPS) * ACC_W'(speed_q);
	assign acc_sum      = {1'b0, acc_q} + (ACC_W + 1)'(speed_q);
	assign acc_step     = (acc_q >= cap) ? acc_q :
		(acc_sum > {1'b0, cap}) ? cap : acc_sum[ACC_W-1:0];

	always_comb begin
		normal_d    = normal_q;
		select_d    = select_q;
		ramp_d      = ramp_q;
		run_d       = run_q;
		pot_time_d  = pot_time_q;
		pot_speed_d = pot_speed_q;
		rt_d        = ramp_time_q;
		speed_d     = speed_q;
		elapsed_d   = elapsed_q;
		last_d      = last_step_q;
		acc_d       = acc_q;
		op_d        = mssr_pkg::CMP_HOLD;
		oc_d        = mssr_pkg::OC_NONE;
		unique case (req_s1)
			mssr_pkg::REQ_TICK: begin
				if (!normal_q) begin
					rt_d    = rt_new;
					speed_d = pot_speed_q;
					op_d    = mssr_pkg::CMP_CLEAR;
				end else if (ramp_q) begin
					elapsed_d = elapsed_next;
					if (ramp_done) begin
						ramp_d = 1'b0;
						run_d  = 1'b1;
						oc_d   = mssr_pkg::OC_DONE;
					end else begin
						if (step_due) begin
							acc_d  = acc_step;
							last_d = elapsed_next;
						end
						op_d = mssr_pkg::CMP_LOAD;
					end
				end
			end
			mssr_pkg::REQ_START: begin
				if (!normal_q) begin
					select_d = 1'b0;
				end else if (!ramp_q && !run_q) begin
					ramp_d    = 1'b1;
					elapsed_d = '0;
					last_d    = '0;
					acc_d     = '0;
					op_d      = mssr_pkg::CMP_CLEAR;
				end
			end
			mssr_pkg::REQ_MODE: begin
				if (normal_q && ramp_q) begin
					oc_d = mssr_pkg::OC_ABORT;
				end
				if (!normal_q) begin
					select_d = 1'b0;
				end
				normal_d = !normal_q;
				ramp_d   = 1'b0;
				run_d    = 1'b0;
				op_d     = mssr_pkg::CMP_CLEAR;
			end
			mssr_pkg::REQ_STOP: begin
				if (normal_q) begin
					if (ramp_q) begin
						oc_d = mssr_pkg::OC_ABORT;
					end
					ramp_d = 1'b0;
					run_d  = 1'b0;
					op_d   = mssr_pkg::CMP_CLEAR;
				end else begin
					select_d = !select_q;
				end
			end
			mssr_pkg::REQ_TIME_POT:  pot_time_d  = pot_sat;
			mssr_pkg::REQ_SPEED_POT: pot_speed_d = pot_sat;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			normal_q    <= 1'b0;
			select_q    <= 1'b0;
			ramp_q      <= 1'b0;
			run_q       <= 1'b0;
			pot_time_q  <= '0;
			pot_speed_q <= '0;
			ramp_time_q <= '0;
			speed_q     <= '0;
			elapsed_q   <= '0;
			last_step_q <= '0;
			acc_q       <= '0;
			delta_q     <= '0;
		end else begin
			if (in_ready) begin
				v1_q <= in_valid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (fire1) begin
				normal_q    <= normal_d;
				select_q    <= select_d;
				ramp_q      <= ramp_d;
				run_q       <= run_d;
				pot_time_q  <= pot_time_d;
				pot_speed_q <= pot_speed_d;
				ramp_time_q <= rt_d;
				speed_q     <= speed_d;
				elapsed_q   <= elapsed_d;
				last_step_q <= last_d;
				acc_q       <= acc_d;
			end
			delta_q <= TIME_W'(delta_prod >> DS);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= mssr_pkg::req_t'(req_type);
			pot_s1 <= pot_value;
		end
		if (fire1) begin
			status_s2.mode_normal <= normal_d;
			status_s2.ramping     <= ramp_d;
			status_s2.running     <= run_d;
			status_s2.select_time <= !normal_d && select_d;
			status_s2.outcome     <= oc_d;
			status_s2.ramp_time   <= rt_d;
			op_s2                 <= op_d;
			acc_s2                <= acc_d;
		end
	end

	assign dn_valid  = v2_q;
	assign dn_status = status_s2;
	assign dn_op     = op_s2;
	assign dn_acc    = acc_s2;

endmodule

`default_nettype wire

>>> rtl/mssr_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module mssr_scale #(
	parameter int RAMP_STEPS = 100,
	parameter int ADC_BITS   = 10,
	localparam int ACC_W     = $clog2(RAMP_STEPS * ((1 << ADC_BITS) - 1) + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  mssr_pkg::status_t             up_status,
	input  mssr_pkg::cmp_op_t             up_op,
	input  logic [ACC_W-1:0]              up_acc,
	input  logic [mssr_pkg::PWM_W-1:0]    pwm_top,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mssr_pkg::status_t             out_status,
	output logic [mssr_pkg::PWM_W-1:0]    duty_compare
);

	localparam int PWM_W  = mssr_pkg::PWM_W;
	localparam int DEN    = RAMP_STEPS * ((1 << ADC_BITS) - 1);
	localparam int DEN_W  = $clog2(DEN + 1);
	localparam int NW     = PWM_W + ACC_W;
	localparam int LSH    = DEN_W - 1;
	localparam int AW     = NW - LSH;
	localparam longint unsigned RM = (64'd1 << NW) / 64'(DEN);
	localparam int RMW    = $clog2(RM + 1);
	localparam int PP_W   = AW + RMW;
	localparam int RW     = DEN_W + 2;

	logic                 en3, en4, en5, en_o;
	logic                 v3_q, v4_q, v5_q, vo_q;
	mssr_pkg::status_t    st_s3, st_s4, st_s5, status_q;
	mssr_pkg::cmp_op_t    op_s3, op_s4, op_s5;
	logic [NW-1:0]        num_s3, num_s4, num_s5, cd_s5;
	logic [PP_W-1:0]      prod_s4;
	logic [PWM_W-1:0]     c0, c0_s5, quot, cmp_q;
	logic [RW-1:0]        rem;

	assign en_o     = !vo_q || out_ready;
	assign en5      = !v5_q || en_o;
	assign en4      = !v4_q || en5;
	assign en3      = !v3_q || en4;
	assign up_ready = en3;

	// estimate is at most two below the true quotient
	assign c0   = PWM_W'(prod_s4 >> AW);
	assign rem  = RW'(num_s5 - cd_s5);
	assign quot = PWM_W'((PWM_W + 1)'(c0_s5) + (PWM_W + 1)'(rem >= RW'(DEN))
		+ (PWM_W + 1)'(rem >= RW'(2 * DEN)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q  <= 1'b0;
			v4_q  <= 1'b0;
			v5_q  <= 1'b0;
			vo_q  <= 1'b0;
			cmp_q <= '0;
		end else begin
			if (en3) begin
				v3_q <= up_valid;
			end
			if (en4) begin
				v4_q <= v3_q;
			end
			if (en5) begin
				v5_q <= v4_q;
			end
			if (en_o) begin
				vo_q <= v5_q;
			end
			if (en_o && v5_q) begin
				unique case (op_s5)
					mssr_pkg::CMP_LOAD:  cmp_q <= quot;
					mssr_pkg::CMP_CLEAR: cmp_q <= '0;
					mssr_pkg::CMP_HOLD:  cmp_q <= cmp_q;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && up_valid) begin
			st_s3  <= up_status;
			op_s3  <= up_op;
			num_s3 <= NW'(pwm_top) * NW'(up_acc);
		end
		if (en4 && v3_q) begin
			st_s4   <= st_s3;
			op_s4   <= op_s3;
			num_s4  <= num_s3;
			prod_s4 <= PP_W'(num_s3 >> LSH) * PP_W'(RM);
		end
		if (en5 && v4_q) begin
			st_s5  <= st_s4;
			op_s5  <= op_s4;
			num_s5 <= num_s4;
			c0_s5  <= c0;
			cd_s5  <= NW'(c0) * NW'(DEN);
		end
		if (en_o && v5_q) begin
			status_q <= st_s5;
		end
	end

	assign out_valid    = vo_q;
	assign out_status   = status_q;
	assign duty_compare = cmp_q;

endmodule

`default_nettype wire

>>> rtl/motor_soft_start_ramp_unit.sv
// Throughput: one item per cycle while the output is not stalled; the six-stage path
//   (input, state update, product, reciprocal estimate, estimate times divisor,
//   correction) holds up to six items.
// Reset: arst_n clears all mode, ramp and pot state and the compare value at once,
//   and loads pwm_top with 7999; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module motor_soft_start_ramp_unit #(
	parameter int RAMP_STEPS = 100,
	parameter int ADC_BITS   = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mssr_pkg::REQ_W-1:0]          req_type,
	input  logic [mssr_pkg::POT_W-1:0]          pot_value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mssr_pkg::PWM_W-1:0]          duty_compare,
	output logic                                mode_normal,
	output logic                                ramping,
	output logic                                running,
	output logic                                select_time,
	output logic [1:0]                          start_outcome,
	output logic [mssr_pkg::TIME_W-1:0]         ramp_time_ms,
	// pwm_top write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mssr_pkg::PWM_W-1:0]          cfg_data
);

	localparam int ACC_W = $clog2(RAMP_STEPS * ((1 << ADC_BITS) - 1) + 1);

	logic [mssr_pkg::PWM_W-1:0]  pwm_top_q;

	// control stage -> scaling pipeline
	logic                        mid_valid;
	logic                        mid_ready;
	mssr_pkg::status_t           mid_status;
	mssr_pkg::cmp_op_t           mid_op;
	logic [ACC_W-1:0]            mid_acc;
	mssr_pkg::status_t           res_status;

	// The user is to write the register only while no transaction is in flight (the block
	// does not enforce this), so the scaling pipeline may read it live at its multiply stage.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q <= mssr_pkg::PWM_TOP_RST;
		end else if (cfg_valid && cfg_ready) begin
			pwm_top_q <= cfg_data;
		end
	end

	// Input register and all mode / ramp state. State advances when an item
	// leaves the input register; the post-update flags, the accumulator and
	// a hold / clear / load code for the compare go downstream.
	mssr_ctrl #(
		.RAMP_STEPS (RAMP_STEPS),
		.ADC_BITS   (ADC_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.pot_value  (pot_value),
		.dn_valid   (mid_valid),
		.dn_ready   (mid_ready),
		.dn_status  (mid_status),
		.dn_op      (mid_op),
		.dn_acc     (mid_acc)
	);

	// compare = floor(pwm_top * acc / (RAMP_STEPS * ADC_MAX)) through a
	// reciprocal estimate and a two-step correction; the compare register
	// at its end is the state reported with every result.
	mssr_scale #(
		.RAMP_STEPS (RAMP_STEPS),
		.ADC_BITS   (ADC_BITS)
	) u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (mid_valid),
		.up_ready     (mid_ready),
		.up_status    (mid_status),
		.up_op        (mid_op),
		.up_acc       (mid_acc),
		.pwm_top      (pwm_top_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_status   (res_status),
		.duty_compare (duty_compare)
	);

	// unpack the status word onto the result ports
	assign mode_normal   = res_status.mode_normal;
	assign ramping       = res_status.ramping;
	assign running       = res_status.running;
	assign select_time   = res_status.select_time;
	assign start_outcome = res_status.outcome;
	assign ramp_time_ms  = res_status.ramp_time;

endmodule

`default_nettype wire

>>> rtl/mssr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mssr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [mssr_pkg::PWM_W-1:0]    duty_compare,
	input logic                          mode_normal,
	input logic                          ramping,
	input logic                          running,
	input logic                          select_time,
	input logic [1:0]                    start_outcome
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty_compare)
			&& $stable(start_outcome))
		else $error("stalled result changed");

	// motor is stopped in configuration mode
	a_cfg_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mode_normal |-> duty_compare == '0 && !ramping && !running)
		else $error("motor driven in configuration mode");

	a_ramp_run_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ramping && running))
		else $error("ramping and running together");

	a_select_cfg_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_normal |-> !select_time)
		else $error("selection shown in normal mode");

	// a finished or aborted ramp is no longer ramping
	a_outcome_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_outcome != mssr_pkg::OC_NONE |-> !ramping)
		else $error("ramp outcome while still ramping");

endmodule

bind motor_soft_start_ramp_unit mssr_checker u_mssr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.duty_compare  (duty_compare),
	.mode_normal   (mode_normal),
	.ramping       (ramping),
	.running       (running),
	.select_time   (select_time),
	.start_outcome (start_outcome)
);

`default_nettype wire

>>> bench/mssr_status_checker.sv
`timescale 1ns / 1ps

module mssr_status_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [mssr_pkg::REQ_W-1:0]    req_type,
	input  logic [mssr_pkg::POT_W-1:0]    pot_value,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [mssr_pkg::PWM_W-1:0]    duty_compare,
	input  logic                          mode_normal,
	input  logic                          ramping,
	input  logic                          running,
	input  logic                          select_time,
	input  logic [1:0]                    start_outcome,
	input  logic [mssr_pkg::TIME_W-1:0]   ramp_time_ms,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [mssr_pkg::PWM_W-1:0]    cfg_data,
	output int                            errors,
	output int                            pending
);
	import mssr_pkg::*;

	localparam int RAMP_STEPS = 100;
	localparam int ADC_MAX    = (1 << POT_W) - 1;

	typedef struct packed {
		logic [PWM_W-1:0] duty;
		status_t          st;
	} ramp_status_t;

	ramp_status_t status_due[$];

	logic [PWM_W-1:0] top_count;
	bit               normal_on, sel_time, ramp_on, motor_on;
	int unsigned      pot_time, pot_speed, ramp_ms, speed_ref;
	int unsigned      elapsed, last_step, duty_acc, cmp_now;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic drop_motor();
		ramp_on  = 1'b0;
		motor_on = 1'b0;
		cmp_now  = 0;
	endtask

	task automatic step_soft_start(input logic [REQ_W-1:0] req, input logic [POT_W-1:0] pot,
			output ramp_status_t res);
		outcome_t          oc;
		int unsigned       delta;
		int unsigned       cap;
		longint unsigned   prod;
		oc = OC_NONE;
		case (req)
			REQ_TICK: begin
				if (!normal_on) begin
					ramp_ms   = (RT_BASE + (pot_time * RT_SPAN) / ADC_MAX) * RT_UNIT_MS;
					speed_ref = pot_speed;
					cmp_now   = 0;
				end else if (ramp_on) begin
					if (elapsed + 1 > ramp_ms) begin
						elapsed  = (elapsed + 1) & 32'h3FFF;
						ramp_on  = 1'b0;
						motor_on = 1'b1;
						oc       = OC_DONE;
					end else begin
						delta   = ramp_ms / RAMP_STEPS;
						cap     = RAMP_STEPS * speed_ref;
						elapsed = (elapsed + 1) & 32'h3FFF;
						if (elapsed - last_step >= delta || elapsed < last_step) begin
							if (duty_acc < cap) begin
								duty_acc += speed_ref;
								if (duty_acc > cap)
									duty_acc = cap;
							end
							last_step = elapsed;
						end
						prod    = longint'(top_count) * longint'(duty_acc);
						cmp_now = (prod / (RAMP_STEPS * ADC_MAX)) & 32'hFFFF;
					end
				end
			end
			REQ_START: begin
				if (!normal_on) begin
					sel_time = 1'b0;
				end else if (!ramp_on && !motor_on) begin
					ramp_on   = 1'b1;
					elapsed   = 0;
					last_step = 0;
					duty_acc  = 0;
					cmp_now   = 0;
				end
			end
			REQ_MODE: begin
				if (normal_on) begin
					if (ramp_on)
						oc = OC_ABORT;
					drop_motor();
					normal_on = 1'b0;
				end else begin
					normal_on = 1'b1;
					sel_time  = 1'b0;
					drop_motor();
				end
			end
			REQ_STOP: begin
				if (normal_on) begin
					if (ramp_on)
						oc = OC_ABORT;
					drop_motor();
				end else begin
					sel_time = !sel_time;
				end
			end
			REQ_TIME_POT:  pot_time  = pot;
			REQ_SPEED_POT: pot_speed = pot;
			default: ;
		endcase
		res.duty           = cmp_now[PWM_W-1:0];
		res.st.mode_normal = normal_on;
		res.st.ramping     = ramp_on;
		res.st.running     = motor_on;
		res.st.select_time = !normal_on && sel_time;
		res.st.outcome     = oc;
		res.st.ramp_time   = ramp_ms[TIME_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ramp_status_t want;
		if (!arst_n) begin
			top_count = PWM_TOP_RST;
			normal_on = 1'b0;
			sel_time  = 1'b0;
			ramp_on   = 1'b0;
			motor_on  = 1'b0;
			pot_time  = 0;
			pot_speed = 0;
			ramp_ms   = 0;
			speed_ref = 0;
			elapsed   = 0;
			last_step = 0;
			duty_acc  = 0;
			cmp_now   = 0;
			errors    = 0;
			status_due.delete();
			pending  <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				top_count = cfg_data;
			if (in_valid && in_ready) begin
				step_soft_start(req_type, pot_value, want);
				status_due.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					report_mismatch("unrequested result, duty_compare", duty_compare, 0);
				end else begin
					want = status_due.pop_front();
					if (duty_compare !== want.duty)
						report_mismatch("duty_compare", duty_compare, want.duty);
					if (mode_normal !== want.st.mode_normal)
						report_mismatch("mode_normal", mode_normal, want.st.mode_normal);
					if (ramping !== want.st.ramping)
						report_mismatch("ramping", ramping, want.st.ramping);
					if (running !== want.st.running)
						report_mismatch("running", running, want.st.running);
					if (select_time !== want.st.select_time)
						report_mismatch("select_time", select_time, want.st.select_time);
					if (start_outcome !== want.st.outcome)
						report_mismatch("start_outcome", start_outcome, want.st.outcome);
					if (ramp_time_ms !== want.st.ramp_time)
						report_mismatch("ramp_time_ms", ramp_time_ms, want.st.ramp_time);
				end
			end
			pending <= status_due.size();
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mssr_pkg::*;

	// Request codes the block leaves unused; it must report its state unchanged
	localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	// Bound on the random part, counted in request transactions
	localparam int RANDOM_ITEMS = 1250;
	// Ticks of the unstalled ramp at the end, well short of its completion
	localparam int FINAL_TICKS = 200;
	// Receiver hold-off used to back the pipeline up into the request side
	localparam int CHOKE_CYCLES = 150;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [REQ_W-1:0]   req_type;
	logic [POT_W-1:0]   pot_value;
	logic               out_valid;
	logic               out_ready;
	logic [PWM_W-1:0]   duty_compare;
	logic               mode_normal;
	logic               ramping;
	logic               running;
	logic               select_time;
	logic [1:0]         start_outcome;
	logic [TIME_W-1:0]  ramp_time_ms;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [PWM_W-1:0]   cfg_data;

	int errors;
	int pending;

	// Stimulus-side bookkeeping: idling switch, long-stall request, mode as sent
	bit idle_on    = 1'b1;
	bit choke_req  = 1'b0;
	bit in_normal  = 1'b0;
	int items_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	motor_soft_start_ramp_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.pot_value     (pot_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.duty_compare  (duty_compare),
		.mode_normal   (mode_normal),
		.ramping       (ramping),
		.running       (running),
		.select_time   (select_time),
		.start_outcome (start_outcome),
		.ramp_time_ms  (ramp_time_ms),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	mssr_status_checker CHK (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.pot_value     (pot_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.duty_compare  (duty_compare),
		.mode_normal   (mode_normal),
		.ramping       (ramping),
		.running       (running),
		.select_time   (select_time),
		.start_outcome (start_outcome),
		.ramp_time_ms  (ramp_time_ms),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	// Pot samples weighted toward both ends of the ADC range
	function automatic logic [POT_W-1:0] rand_pot();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return POT_W'($urandom_range(0, (1 << POT_W) - 1));
		endcase
	endfunction

	// Anything but a mode press or a tick, to sprinkle into a running ramp
	function automatic logic [REQ_W-1:0] ramp_noise_req();
		case ($urandom_range(0, 5))
			0: return REQ_START;
			1: return REQ_STOP;
			2: return REQ_TIME_POT;
			3: return REQ_SPEED_POT;
			4: return REQ_SPARE_6;
			default: return REQ_SPARE_7;
		endcase
	endfunction

	// Offer one request transaction and hold it until accepted. Valid stays
	// high across back-to-back transactions; drop it only for an idle gap.
	task automatic send_item(input logic [REQ_W-1:0] req, input logic [POT_W-1:0] pot);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		pot_value <= pot;
		do @(posedge clk); while (!in_ready);
		// A mode press always flips the mode, so track it here for sequencing
		if (req == REQ_MODE)
			in_normal = !in_normal;
		items_sent++;
	endtask

	// Drop valid and wait until every expected result is back, then let the
	// pipeline settle past its latency before touching the register.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_top(input logic [PWM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One well-formed soft-start attempt: configure pots, latch them, enter
	// normal mode, start, tick for a while with occasional noise, then end it or leave it.
	task automatic run_ramp_sequence();
		if (in_normal)
			send_item(REQ_MODE, rand_pot());
		if ($urandom_range(0, 2) == 0)
			send_item(REQ_STOP, rand_pot());
		if ($urandom_range(0, 3) == 0)
			send_item(REQ_START, rand_pot());
		send_item(REQ_TIME_POT, rand_pot());
		send_item(REQ_SPEED_POT, rand_pot());
		repeat ($urandom_range(1, 3)) send_item(REQ_TICK, rand_pot());
		send_item(REQ_MODE, rand_pot());
		send_item(REQ_START, rand_pot());
		repeat ($urandom_range(1, 250)) begin
			if ($urandom_range(0, 11) == 0)
				send_item(ramp_noise_req(), POT_W'($urandom_range(0, (1 << POT_W) - 1)));
			send_item(REQ_TICK, POT_W'($urandom_range(0, (1 << POT_W) - 1)));
		end
		case ($urandom_range(0, 2))
			0: send_item(REQ_STOP, rand_pot());
			1: send_item(REQ_MODE, rand_pot());
			default: ;
		endcase
	endtask

	// Result side: random ready bursts, one long hold-off on request, and
	// ready held high once idling is switched off.
	initial begin : result_sink
		int held;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (choke_req) begin
				choke_req = 1'b0;
				out_ready <= 1'b0;
				held = 0;
				while (held < CHOKE_CYCLES) begin
					@(posedge clk);
					held++;
				end
			end else if (!idle_on) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 5) == 0) begin
				// stretch with no stalls at all
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int k;
		int base;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = REQ_TICK;
		pot_value = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, default pwm_top. Unused codes must leave state alone.
		send_item(REQ_SPARE_6, '1);
		send_item(REQ_SPARE_7, '0);
		// Enter normal mode before any latch tick: ramp time is still zero,
		// so the first tick after start completes the ramp.
		send_item(REQ_MODE, '0);
		send_item(REQ_TICK, '0);
		send_item(REQ_START, '0);
		send_item(REQ_TICK, '0);
		// Start while running is ignored; stop halts; stop when idle does nothing
		send_item(REQ_START, '0);
		send_item(REQ_STOP, '0);
		send_item(REQ_STOP, '0);
		// Back to configuration: stop toggles the selection, start clears it
		send_item(REQ_MODE, '0);
		send_item(REQ_STOP, '0);
		send_item(REQ_START, '0);
		send_item(REQ_STOP, '0);
		// Latch the longest ramp at full speed, then the shortest
		send_item(REQ_TIME_POT, '1);
		send_item(REQ_SPEED_POT, '1);
		send_item(REQ_TICK, '0);
		send_item(REQ_TIME_POT, '0);
		send_item(REQ_TICK, '1);
		// Normal mode clears the selection; abort by stop, then by mode press
		send_item(REQ_MODE, '0);
		send_item(REQ_START, '0);
		repeat (3) send_item(REQ_TICK, '0);
		send_item(REQ_STOP, '0);
		send_item(REQ_START, '0);
		send_item(REQ_TICK, '0);
		send_item(REQ_MODE, '0);

		// Random part: ramp sequences with noise, pwm_top changed every third
		// sequence while the block is idle, extremes first.
		base = items_sent;
		k = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			if (k % 3 == 0) begin
				drain();
				case ((k / 3) % 6)
					0: write_top(16'd1);
					1: write_top(16'hFFFF);
					2: write_top(16'd0);
					3: write_top(PWM_TOP_RST);
					default: write_top(PWM_W'($urandom_range(1, 16'hFFFF)));
				endcase
				// Hold the receiver off once the block is empty, then keep
				// offering transactions until the input stalls.
				if (k == 0) begin
					choke_req = 1'b1;
					wait (!choke_req);
				end
			end
			run_ramp_sequence();
			repeat ($urandom_range(0, 4))
				send_item(REQ_W'($urandom_range(0, 7)),
					POT_W'($urandom_range(0, (1 << POT_W) - 1)));
			k++;
		end

		// Last part, no idling: the shortest ramp at top speed and the widest
		// PWM period, ticked for a while and then stopped.
		idle_on = 1'b0;
		drain();
		write_top(16'hFFFF);
		if (in_normal)
			send_item(REQ_MODE, '0);
		send_item(REQ_TIME_POT, '0);
		send_item(REQ_SPEED_POT, '1);
		send_item(REQ_TICK, '0);
		send_item(REQ_MODE, '0);
		send_item(REQ_START, '0);
		repeat (FINAL_TICKS)
			send_item(REQ_TICK, POT_W'($urandom_range(0, (1 << POT_W) - 1)));
		send_item(REQ_STOP, '0);
		drain();

		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/mssr_pkg.sv
rtl/mssr_ctrl.sv
rtl/mssr_scale.sv
rtl/motor_soft_start_ramp_unit.sv
rtl/mssr_checker.sv
bench/mssr_status_checker.sv
bench/tb_top.sv
